// ===== rtl/core/fcs_pkg.sv =====
package fcs_pkg;

  localparam int unsigned DepthLimit   = 8;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned TableAw      = 10;
  localparam logic [63:0] FnvPrime     = 64'h0000_0100_0000_01B3;

  // Input item kinds.
  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeNext  = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;

  // Configuration register indices.
  localparam logic [1:0] RegCharset = 2'd0;
  localparam logic [1:0] RegDepth   = 2'd1;
  localparam logic [1:0] RegStart   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] target_hash;
    logic [15:0] target_tag;
    logic [63:0] prefix_hash;
    logic [7:0]  prefix_id;
  } item_t;

  typedef struct packed {
    logic [63:0] candidate_hash;
    logic [47:0] candidate_chars;
    logic [3:0]  candidate_length;
    logic [7:0]  run_prefix;
    logic        matched;
    logic [15:0] match_tag;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] tag;
  } entry_t;

  // Number of characters in each built-in alphabet; unknown selections are empty.
  function automatic logic [6:0] alpha_len(input logic [3:0] sel);
    logic [6:0] n;
    begin
      case (sel)
        4'd0:    n = 7'd26;
        4'd1:    n = 7'd26;
        4'd2:    n = 7'd10;
        4'd3:    n = 7'd52;
        4'd4:    n = 7'd62;
        4'd5:    n = 7'd53;
        4'd6:    n = 7'd63;
        4'd7:    n = 7'd37;
        4'd8:    n = 7'd27;
        4'd9:    n = 7'd20;
        default: n = 7'd0;
      endcase
      return n;
    end
  endfunction

  // The ten letters of the frequency alphabet, upper case.
  function automatic logic [7:0] freq_letter(input logic [3:0] k);
    logic [7:0] c;
    begin
      case (k)
        4'd0:    c = 8'h53;
        4'd1:    c = 8'h52;
        4'd2:    c = 8'h45;
        4'd3:    c = 8'h41;
        4'd4:    c = 8'h49;
        4'd5:    c = 8'h54;
        4'd6:    c = 8'h4F;
        4'd7:    c = 8'h4E;
        4'd8:    c = 8'h4C;
        default: c = 8'h44;
      endcase
      return c;
    end
  endfunction

  // ASCII code of the character at a position of the selected alphabet.
  function automatic logic [7:0] alpha_char(input logic [3:0] sel, input logic [5:0] pos);
    logic [7:0] p;
    logic [7:0] c;
    begin
      p = {2'b00, pos};
      case (sel)
        4'd0: c = 8'h41 + p;
        4'd1: c = 8'h61 + p;
        4'd2: c = 8'h30 + p;
        4'd3: c = (p < 8'd26) ? 8'h41 + p : 8'h61 + p - 8'd26;
        4'd4: c = (p < 8'd26) ? 8'h41 + p : (p < 8'd52) ? 8'h61 + p - 8'd26 : 8'h30 + p - 8'd52;
        4'd5: c = (p < 8'd26) ? 8'h41 + p : (p < 8'd52) ? 8'h61 + p - 8'd26 : 8'h5F;
        4'd6: c = (p < 8'd26) ? 8'h41 + p : (p < 8'd52) ? 8'h61 + p - 8'd26 :
                  (p < 8'd62) ? 8'h30 + p - 8'd52 : 8'h5F;
        4'd7: c = (p < 8'd26) ? 8'h61 + p : (p < 8'd36) ? 8'h30 + p - 8'd26 : 8'h5F;
        4'd8: c = (p < 8'd26) ? 8'h41 + p : 8'h5F;
        4'd9: c = (p < 8'd10) ? freq_letter(pos[3:0]) :
                  freq_letter(4'(pos - 6'd10)) + 8'h20;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== rtl/core/fcs_char_step.sv =====
// One FNV-1a character step. The prime is 2^40 + 0x1B3, so the product
// modulo 2^64 is a shift plus a narrow 64 by 9 bit multiplication.
module fcs_char_step (
  input  logic [63:0] hash_in,
  input  logic [3:0]  charset,
  input  logic [5:0]  pos,
  output logic [63:0] hash_out
);

  logic [63:0] mixed;
  logic [63:0] low_part;

  assign mixed    = hash_in ^ {56'd0, fcs_pkg::alpha_char(charset, pos)};
  assign low_part = mixed * 64'(fcs_pkg::FnvPrime[8:0]);
  assign hash_out = {mixed[23:0], 40'd0} + low_part;

endmodule

// ===== rtl/core/fnv1a_candidate_search.sv =====
// FNV-1a candidate search.
// Items arrive on the item channel (item_valid, item_stall, item) and results
// leave on the result channel (result_valid, result_stall, result); a transfer
// happens when valid is high and stall is low. Configuration is written through
// cfg_write, cfg_index and cfg_data; the user must do so only while the block is
// idle, which the block itself does not enforce. A load item scans the target
// table entry by entry, reading and then comparing each one, then writes a new
// tag on a match or, while the table has room, a new entry. A start item gives
// no result. A next item during a run scans the table the same way, then walks
// the depth-first enumeration one level per cycle and hands its result to the
// output register. The table scan goes through the single read port of the
// table memory. Items are taken one at a time; item_stall is high while an item
// is in work.
// The output register holds one result, so a new item is accepted while that
// result still waits; a next item that finishes while result_stall holds the
// previous result waits for it to leave. Reset (rst, synchronous) empties the
// table by clearing the fill count, ends any run and rearms the start-index skip;
// no clearing pass is needed.
module fnv1a_candidate_search (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  fcs_pkg::item_t         item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output fcs_pkg::result_t       result,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [5:0]             cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_LD_RD, S_LD_CMP, S_NX_RD, S_NX_CMP, S_ADV_DOWN, S_ADV_UP, S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [3:0] charset_select;
  logic [3:0] max_depth;
  logic [5:0] start_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_select <= '0;
      max_depth      <= '0;
      start_index    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcs_pkg::RegCharset: charset_select <= cfg_data[3:0];
        fcs_pkg::RegDepth:   max_depth      <= cfg_data[3:0];
        fcs_pkg::RegStart:   start_index    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Target table memory: one write port, one registered read port.
  fcs_pkg::entry_t                table_mem [fcs_pkg::TableEntries];
  fcs_pkg::entry_t                rd_entry;
  logic                           wr_en;
  logic [fcs_pkg::TableAw-1:0]    wr_addr;
  fcs_pkg::entry_t                wr_entry;
  logic [10:0]                    probe;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= table_mem[probe[fcs_pkg::TableAw-1:0]];
  end

  // Search state.
  logic [10:0] entries_loaded;
  logic [63:0] level_hash [fcs_pkg::DepthLimit + 1];
  logic [5:0]  level_position [fcs_pkg::DepthLimit];
  logic [3:0]  current_length;
  logic        run_active;
  logic        skip_pending;
  logic [7:0]  active_prefix;

  // Item being worked on.
  logic [63:0] work_hash;
  logic [15:0] work_tag;
  logic [3:0]  walk_len;
  logic        hit;
  logic [15:0] hit_tag;
  logic        more;
  logic [47:0] snap_chars;
  logic [3:0]  snap_len;

  // Derived limits, read live from the registers.
  logic [6:0] alen;
  logic [3:0] depth;
  logic [6:0] down_pos;
  logic [6:0] up_pos;
  logic       entry_hit;

  assign alen      = fcs_pkg::alpha_len(charset_select);
  assign depth     = (max_depth > 4'(fcs_pkg::DepthLimit)) ? 4'(fcs_pkg::DepthLimit) : max_depth;
  assign down_pos  = (current_length == 4'd0 && skip_pending) ? {1'b0, start_index} : 7'd0;
  assign up_pos    = {1'b0, level_position[3'(walk_len - 4'd1)]} + 7'd1;
  assign entry_hit = rd_entry.valid && (rd_entry.key == work_hash);

  // Shared character step unit.
  logic [3:0]  step_level;
  logic [5:0]  step_pos;
  logic [63:0] step_hash;

  always_comb begin
    if (state == S_ADV_UP) begin
      step_level = walk_len - 4'd1;
      step_pos   = up_pos[5:0];
    end else begin
      step_level = current_length;
      step_pos   = down_pos[5:0];
    end
  end

  fcs_char_step u_step (
    .hash_in  (level_hash[step_level]),
    .charset  (charset_select),
    .pos      (step_pos),
    .hash_out (step_hash)
  );

  // Candidate characters packed from the level positions.
  logic [47:0] packed_chars;

  always_comb begin
    packed_chars = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < current_length) begin
        packed_chars[6*i +: 6] = level_position[i];
      end
    end
  end

  // Table write port.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = probe[fcs_pkg::TableAw-1:0];
    wr_entry = '{valid: 1'b1, key: work_hash, tag: work_tag};
    if (state == S_LD_RD && probe >= entries_loaded &&
        entries_loaded < 11'(fcs_pkg::TableEntries)) begin
      wr_en   = 1'b1;
      wr_addr = entries_loaded[fcs_pkg::TableAw-1:0];
    end else if (state == S_LD_CMP && entry_hit) begin
      wr_en = 1'b1;
    end else if (state == S_NX_CMP && entry_hit) begin
      wr_en    = 1'b1;
      wr_entry = '{valid: 1'b0, key: rd_entry.key, tag: rd_entry.tag};
    end
  end

  assign item_stall = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_loaded <= '0;
      current_length <= '0;
      run_active     <= 1'b0;
      skip_pending   <= 1'b1;
      active_prefix  <= '0;
      result_valid   <= 1'b0;
      probe          <= '0;
      for (int i = 0; i < fcs_pkg::DepthLimit; i++) begin
        level_position[i] <= '0;
      end
    end else begin
      // Output register: take a finished result, or empty on a transfer.
      if (state == S_FIN && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          probe <= '0;
          if (item_valid) begin
            case (item.mode)
              fcs_pkg::ModeLoad: begin
                work_hash <= item.target_hash;
                work_tag  <= item.target_tag;
                state     <= S_LD_RD;
              end
              fcs_pkg::ModeStart: begin
                level_hash[0]  <= item.prefix_hash;
                active_prefix  <= item.prefix_id;
                current_length <= '0;
                run_active     <= 1'b1;
                for (int i = 0; i < fcs_pkg::DepthLimit; i++) begin
                  level_position[i] <= '0;
                end
              end
              fcs_pkg::ModeNext: begin
                if (run_active) begin
                  work_hash  <= level_hash[current_length];
                  snap_chars <= packed_chars;
                  snap_len   <= current_length;
                  hit        <= 1'b0;
                  hit_tag    <= '0;
                  state      <= S_NX_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: begin
          if (probe < entries_loaded) begin
            state <= S_LD_CMP;
          end else begin
            if (entries_loaded < 11'(fcs_pkg::TableEntries)) begin
              entries_loaded <= entries_loaded + 11'd1;
            end
            state <= S_IDLE;
          end
        end
        S_LD_CMP: begin
          probe <= probe + 11'd1;
          state <= entry_hit ? S_IDLE : S_LD_RD;
        end
        S_NX_RD: begin
          state <= (probe < entries_loaded) ? S_NX_CMP : S_ADV_DOWN;
        end
        S_NX_CMP: begin
          probe <= probe + 11'd1;
          if (entry_hit) begin
            hit     <= 1'b1;
            hit_tag <= rd_entry.tag;
            state   <= S_ADV_DOWN;
          end else begin
            state <= S_NX_RD;
          end
        end
        S_ADV_DOWN: begin
          // Descend one level where depth and the alphabet allow it.
          walk_len <= current_length;
          if (current_length < depth) begin
            if (current_length == 4'd0 && skip_pending) begin
              skip_pending <= 1'b0;
            end
          end
          if (current_length < depth && down_pos < alen) begin
            level_position[current_length[2:0]] <= down_pos[5:0];
            level_hash[current_length + 4'd1]   <= step_hash;
            current_length                      <= current_length + 4'd1;
            more                                <= 1'b1;
            state                               <= S_FIN;
          end else begin
            state <= S_ADV_UP;
          end
        end
        S_ADV_UP: begin
          // Move to the next sibling, climbing one level a cycle.
          if (walk_len == 4'd0) begin
            current_length <= '0;
            more           <= 1'b0;
            state          <= S_FIN;
          end else if (up_pos < alen && walk_len <= depth) begin
            level_position[3'(walk_len - 4'd1)] <= up_pos[5:0];
            level_hash[walk_len]                <= step_hash;
            current_length                      <= walk_len;
            more                                <= 1'b1;
            state                               <= S_FIN;
          end else begin
            walk_len <= walk_len - 4'd1;
          end
        end
        S_FIN: begin
          // Hand the result over once the output register is free.
          if (!result_valid || !result_stall) begin
            result.candidate_hash   <= work_hash;
            result.candidate_chars  <= snap_chars;
            result.candidate_length <= snap_len;
            result.run_prefix       <= active_prefix;
            result.matched          <= hit;
            result.match_tag        <= hit_tag;
            result.last             <= !more;
            if (!more) begin
              run_active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/fnv1a_candidate_search_test.sv =====
`timescale 1ns / 100ps

module fnv1a_candidate_search_test;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  fcs_pkg::item_t    item;
  logic              result_valid;
  logic              result_stall;
  fcs_pkg::result_t  result;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [5:0]        cfg_data;

  fnv1a_candidate_search dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Built-in alphabets in selection order.
  string alphabet [10] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "abcdefghijklmnopqrstuvwxyz",
    "0123456789",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_",
    "abcdefghijklmnopqrstuvwxyz0123456789_",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ_",
    "SREAITONLDsreaitonld"
  };

  // Register copies held by the predictor.
  int unsigned sel_charset;
  int unsigned sel_depth;
  int unsigned sel_start;

  // Target table and enumeration state of the predictor.
  logic [63:0] key_mem   [fcs_pkg::TableEntries];
  logic [15:0] tag_mem   [fcs_pkg::TableEntries];
  bit          live_mem  [fcs_pkg::TableEntries];
  int unsigned keys_loaded;
  logic [63:0] walk_hash [fcs_pkg::DepthLimit + 1];
  int unsigned walk_pos  [fcs_pkg::DepthLimit];
  int unsigned walk_len;
  bit          walking;
  bit          skip_armed;
  logic [7:0]  walk_prefix;

  fcs_pkg::result_t pending_candidates [$];
  logic [63:0]      prefix_pool [$];
  bit               failed;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  function automatic int unsigned alphabet_size();
    return (sel_charset < 10) ? alphabet[sel_charset].len() : 0;
  endfunction

  function automatic logic [63:0] fnv_step(logic [63:0] h, int unsigned pos);
    logic [7:0] c;
    c = alphabet[sel_charset][pos];
    return (h ^ {56'd0, c}) * fcs_pkg::FnvPrime;
  endfunction

  // Moves the enumeration to the next candidate in pre-order; 0 when exhausted.
  function automatic bit walk_forward();
    int unsigned alen;
    int unsigned lim;
    int unsigned len;
    int unsigned s;
    int unsigned p;
    alen = alphabet_size();
    lim  = (sel_depth > fcs_pkg::DepthLimit) ? fcs_pkg::DepthLimit : sel_depth;
    len  = walk_len;
    if (len < lim) begin
      s = 0;
      if (len == 0 && skip_armed) begin
        s = sel_start;
        skip_armed = 1'b0;
      end
      if (s < alen) begin
        walk_pos[len] = s;
        walk_hash[len + 1] = fnv_step(walk_hash[len], s);
        walk_len = len + 1;
        return 1'b1;
      end
    end
    if (len > fcs_pkg::DepthLimit) len = fcs_pkg::DepthLimit;
    while (len > 0) begin
      p = walk_pos[len - 1] + 1;
      if (p < alen && len <= lim) begin
        walk_pos[len - 1] = p;
        walk_hash[len] = fnv_step(walk_hash[len - 1], p);
        walk_len = len;
        return 1'b1;
      end
      len--;
    end
    walk_len = 0;
    return 1'b0;
  endfunction

  // Updates the predictor with one accepted item and gives its candidate, if any.
  function automatic bit predict_candidate(fcs_pkg::item_t it, output fcs_pkg::result_t r);
    int unsigned len;
    bit more;
    r = '0;
    case (it.mode)
      fcs_pkg::ModeLoad: begin
        for (int unsigned i = 0; i < keys_loaded; i++) begin
          if (live_mem[i] && key_mem[i] == it.target_hash) begin
            tag_mem[i] = it.target_tag;
            return 1'b0;
          end
        end
        if (keys_loaded < fcs_pkg::TableEntries) begin
          key_mem[keys_loaded]  = it.target_hash;
          tag_mem[keys_loaded]  = it.target_tag;
          live_mem[keys_loaded] = 1'b1;
          keys_loaded++;
        end
        return 1'b0;
      end
      fcs_pkg::ModeStart: begin
        walk_hash[0] = it.prefix_hash;
        walk_prefix  = it.prefix_id;
        foreach (walk_pos[i]) walk_pos[i] = 0;
        walk_len = 0;
        walking  = 1'b1;
        return 1'b0;
      end
      fcs_pkg::ModeNext: begin
        if (!walking) return 1'b0;
        len = (walk_len > fcs_pkg::DepthLimit) ? fcs_pkg::DepthLimit : walk_len;
        r.candidate_hash   = walk_hash[len];
        for (int unsigned i = 0; i < len && i < 8; i++)
          r.candidate_chars[6*i +: 6] = walk_pos[i][5:0];
        r.candidate_length = len[3:0];
        r.run_prefix       = walk_prefix;
        for (int unsigned i = 0; i < keys_loaded; i++) begin
          if (live_mem[i] && key_mem[i] == r.candidate_hash) begin
            r.matched   = 1'b1;
            r.match_tag = tag_mem[i];
            live_mem[i] = 1'b0;
            break;
          end
        end
        more = walk_forward();
        if (!more) walking = 1'b0;
        r.last = !more;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A key that a run from a pooled prefix can reach under the present settings.
  function automatic logic [63:0] reachable_key();
    logic [63:0] h;
    int unsigned n;
    int unsigned lim;
    h   = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
    lim = (sel_depth > 3) ? 3 : sel_depth;
    n   = (alphabet_size() > 0) ? $urandom_range(lim) : 0;
    for (int unsigned i = 0; i < n; i++)
      h = fnv_step(h, $urandom_range(alphabet_size() - 1));
    return h;
  endfunction

  // Offers one item and waits for its transfer; the predictor is updated then.
  task automatic offer_item(fcs_pkg::item_t it, bit typed, fcs_pkg::result_t typed_want);
    fcs_pkg::result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    if (predict_candidate(it, r)) pending_candidates.push_back(typed ? typed_want : r);
    if (it.mode == fcs_pkg::ModeStart && prefix_pool.size() < 16)
      prefix_pool.push_back(it.prefix_hash);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fcs_pkg::RegCharset: sel_charset = val[3:0];
      fcs_pkg::RegDepth:   sel_depth   = val[3:0];
      default:             sel_start   = val;
    endcase
  endtask

  // Lets every expected candidate leave, then covers the scan of a trailing load.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_candidates.size() > 0) @(posedge clk);
    repeat (2 * keys_loaded + 40) @(posedge clk);
  endtask

  function automatic fcs_pkg::item_t random_item(logic [1:0] mode);
    fcs_pkg::item_t it;
    it.mode        = mode;
    it.target_hash = {$urandom, $urandom};
    it.target_tag  = 16'($urandom);
    it.prefix_hash = {$urandom, $urandom};
    it.prefix_id   = 8'($urandom);
    return it;
  endfunction

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A transfer happens at the next rising edge; outputs are stable here.
  always @(negedge clk) begin
    fcs_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_candidates.size() == 0) begin
        $display("%0t: unexpected candidate %h", $time, result);
        failed = 1'b1;
      end else begin
        want = pending_candidates.pop_front();
        if (result.candidate_hash !== want.candidate_hash) begin
          $display("%0t: candidate_hash expected %h actual %h",
                   $time, want.candidate_hash, result.candidate_hash);
          failed = 1'b1;
        end
        if (result.candidate_chars !== want.candidate_chars) begin
          $display("%0t: candidate_chars expected %h actual %h",
                   $time, want.candidate_chars, result.candidate_chars);
          failed = 1'b1;
        end
        if (result.candidate_length !== want.candidate_length) begin
          $display("%0t: candidate_length expected %0d actual %0d",
                   $time, want.candidate_length, result.candidate_length);
          failed = 1'b1;
        end
        if (result.run_prefix !== want.run_prefix) begin
          $display("%0t: run_prefix expected %h actual %h",
                   $time, want.run_prefix, result.run_prefix);
          failed = 1'b1;
        end
        if (result.matched !== want.matched) begin
          $display("%0t: matched expected %b actual %b", $time, want.matched, result.matched);
          failed = 1'b1;
        end
        if (result.match_tag !== want.match_tag) begin
          $display("%0t: match_tag expected %h actual %h",
                   $time, want.match_tag, result.match_tag);
          failed = 1'b1;
        end
        if (result.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, result.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Hard limit on the length of the run.
  initial begin
    #200ms;
    $display("fnv1a_candidate_search test failed");
    $finish;
  end

  typedef struct {
    fcs_pkg::item_t   it;
    bit               typed;
    fcs_pkg::result_t want;
  } stim_row_t;

  initial begin
    stim_row_t        rows [$];
    stim_row_t        row;
    fcs_pkg::item_t   it;
    fcs_pkg::result_t none;
    logic [63:0]      ph;
    int unsigned      roll;
    int unsigned phase_charset [10] = '{0, 9, 2, 15, 4, 6, 7, 8, 3, 1};
    int unsigned phase_depth   [10] = '{1, 2, 3, 2, 0, 2, 12, 1, 2, 15};
    int unsigned idle_send     [4]  = '{0, 48, 0, 18};
    int unsigned idle_recv     [4]  = '{0, 0, 48, 18};

    failed = 1'b0;
    none = '0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = fcs_pkg::RegCharset;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sel_charset = 0;
    sel_depth = 0;
    sel_start = 0;
    keys_loaded = 0;
    foreach (live_mem[i]) live_mem[i] = 1'b0;
    foreach (walk_pos[i]) walk_pos[i] = 0;
    walk_len = 0;
    walking = 1'b0;
    skip_armed = 1'b1;
    walk_prefix = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Digits, one level, and a start index past the end of the alphabet.
    write_reg(fcs_pkg::RegCharset, 6'd2);
    write_reg(fcs_pkg::RegDepth, 6'd1);
    write_reg(fcs_pkg::RegStart, 6'd62);
    ph = 64'hCBF2_9CE4_8422_2325;

    // Directed table: next with no run, unused mode, duplicate and extreme keys,
    // the emptied first level, a start over a running run, matches and clearing.
    row.typed = 1'b0;
    row.want = none;
    row.it = random_item(fcs_pkg::ModeNext);                     rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeSpare);                    rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeLoad); row.it.target_hash = ph;
    row.it.target_tag = 16'hFFFF;                                rows.push_back(row);
    row.it.target_tag = 16'h1234;                                rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeLoad); row.it.target_hash = '0;
    row.it.target_tag = '0;                                      rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeLoad); row.it.target_hash = '1;
    row.it.target_tag = 16'h0001;                                rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeStart); row.it.prefix_hash = ph;
    row.it.prefix_id = 8'hFF;                                    rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeNext); row.typed = 1'b1;
    row.want = '{candidate_hash: ph, candidate_chars: '0, candidate_length: '0,
                 run_prefix: 8'hFF, matched: 1'b1, match_tag: 16'h1234, last: 1'b1};
    rows.push_back(row);
    row.typed = 1'b0;
    row.it = random_item(fcs_pkg::ModeNext);                     rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeStart); row.it.prefix_hash = ph;
    row.it.prefix_id = 8'h5A;                                    rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeNext);                     rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeNext);                     rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeStart); row.it.prefix_hash = '0;
    row.it.prefix_id = 8'h00;                                    rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeNext); row.typed = 1'b1;
    row.want = '{candidate_hash: '0, candidate_chars: '0, candidate_length: '0,
                 run_prefix: 8'h00, matched: 1'b1, match_tag: 16'h0000, last: 1'b0};
    rows.push_back(row);
    row.typed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      row.it = random_item(fcs_pkg::ModeNext);                   rows.push_back(row);
    end
    row.it = random_item(fcs_pkg::ModeStart); row.it.prefix_hash = '1;
    row.it.prefix_id = 8'hC3;                                    rows.push_back(row);
    row.it = random_item(fcs_pkg::ModeNext); row.typed = 1'b1;
    row.want = '{candidate_hash: '1, candidate_chars: '0, candidate_length: '0,
                 run_prefix: 8'hC3, matched: 1'b1, match_tag: 16'h0001, last: 1'b0};
    rows.push_back(row);
    row.typed = 1'b0;
    for (int i = 0; i < 11; i++) begin
      row.it = random_item(fcs_pkg::ModeNext);                   rows.push_back(row);
    end
    foreach (rows[i]) offer_item(rows[i].it, rows[i].typed, rows[i].want);
    settle();

    // Random phases under a range of settings and idling patterns.
    for (int p = 0; p < 10; p++) begin
      write_reg(fcs_pkg::RegCharset, 6'(phase_charset[p]));
      write_reg(fcs_pkg::RegDepth, 6'(phase_depth[p]));
      write_reg(fcs_pkg::RegStart, 6'($urandom_range(63)));
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      for (int n = 0; n < 42; n++) begin
        roll = $urandom_range(99);
        if (roll < 12) begin
          it = random_item(fcs_pkg::ModeLoad);
          if (roll < 8) it.target_hash = reachable_key();
        end else if (roll < 20) begin
          it = random_item(fcs_pkg::ModeStart);
          if (roll < 15) it.prefix_hash = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
        end else if (roll < 24) begin
          it = random_item(fcs_pkg::ModeSpare);
        end else begin
          it = random_item(fcs_pkg::ModeNext);
        end
        offer_item(it, 1'b0, none);
      end
      settle();
    end

    // Load a few more keys, then search once more under light stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 18;
    write_reg(fcs_pkg::RegCharset, 6'd2);
    write_reg(fcs_pkg::RegDepth, 6'd2);
    for (int i = 0; i < 4; i++) begin
      it = random_item(fcs_pkg::ModeLoad);
      if (i < 2) it.target_hash = reachable_key();
      offer_item(it, 1'b0, none);
    end
    it = random_item(fcs_pkg::ModeStart);
    it.prefix_hash = prefix_pool[0];
    offer_item(it, 1'b0, none);
    for (int i = 0; i < 12; i++) offer_item(random_item(fcs_pkg::ModeNext), 1'b0, none);
    settle();

    if (!failed) begin
      $display("fnv1a_candidate_search test passed");
    end else begin
      $display("fnv1a_candidate_search test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fcs_pkg.sv
rtl/core/fcs_char_step.sv
rtl/core/fnv1a_candidate_search.sv
tb/sv/fnv1a_candidate_search_test.sv
